[rtl/tta_pkg.sv]
// shared constants for the triangle tangent assembler
package tta_pkg;

    // register indexes
    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    // fixed-point constants of the tangent path
    localparam int TAN_FRAC  = 14;
    localparam int NORM_BITS = 31;
    localparam int TAN_W     = 16;

endpackage

[rtl/tta_if.sv]
// valid/ready channel carrying a generic payload
interface tta_if #(
    parameter int W = 8
) (
    input logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/tta_front.sv]
// front end: offsets the position, holds corners, forms the three raw tangent terms
module tta_front #(
    parameter int CW = 32,
    parameter int MW = 16,
    parameter int PW = 48,
    parameter int MAGW = 130
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [CW-1:0]          i_pos_x,
    input  logic [CW-1:0]          i_pos_y,
    input  logic [CW-1:0]          i_pos_z,
    input  logic [CW-1:0]          i_tex_u,
    input  logic [CW-1:0]          i_tex_v,
    input  logic                   i_has_tex,
    input  logic [MW-1:0]          i_material,
    input  logic [CW-1:0]          i_off_x,
    input  logic [CW-1:0]          i_off_y,
    input  logic [CW-1:0]          i_off_z,
    // triangle handed to the back end
    output logic                   o_tri_valid,
    input  logic                   i_tri_ready,
    output logic [3*PW-1:0]        o_tri_corners,
    output logic [3*MAGW-1:0]      o_tri_mag,
    output logic [2:0]             o_tri_neg
);
    // corner payload: x,y,z,u,v,material
    logic [1:0]    r_count;
    logic [PW-1:0] r_c0, r_c1;
    logic [CW-1:0] w_p [3];
    logic [CW-1:0] w_u, w_v;
    logic [PW-1:0] w_cur;

    // multiply stage
    logic                r_busy;
    logic [1:0]          r_step;
    logic [3*PW-1:0]     r_corners;
    logic [CW:0]         r_e1 [3];
    logic [CW:0]         r_e2 [3];
    logic [CW:0]         r_d1, r_d2;
    logic [2:0]          r_neg;
    logic [3*MAGW-1:0]   r_mag;
    logic                r_done;

    assign w_p[0] = i_pos_x + i_off_x;
    assign w_p[1] = i_pos_y + i_off_y;
    assign w_p[2] = i_pos_z + i_off_z;
    assign w_u    = i_has_tex ? i_tex_u : '0;
    assign w_v    = i_has_tex ? i_tex_v : '0;
    assign w_cur  = {w_p[0], w_p[1], w_p[2], w_u, w_v, i_material};

    assign o_in_ready = !r_busy;

    // component products for the current step
    logic signed [2*CW+1:0] w_pp, w_qq, w_tt;
    logic [MAGW-1:0]        w_abs;
    always_comb begin
        w_pp  = $signed(r_e1[r_step]) * $signed(r_d2);
        w_qq  = $signed(r_e2[r_step]) * $signed(r_d1);
        w_tt  = w_pp - w_qq;
        w_abs = MAGW'(w_tt[2*CW+1] ? -w_tt : w_tt);
    end

    // sign-extended field of a held corner
    function automatic logic [CW:0] fld(input logic [PW-1:0] c, input int k);
        fld = {c[PW-1-k*CW], c[PW-1-k*CW -: CW]};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            if (r_done && i_tri_ready) begin
                r_done <= 1'b0;
                r_busy <= 1'b0;
            end
            if (r_busy && !r_done) begin
                r_mag[r_step*MAGW +: MAGW] <= w_abs;
                r_neg[r_step] <= w_tt[2*CW+1];
                if (r_step == 2'd2) begin
                    r_done <= 1'b1;
                end
                r_step <= r_step + 2'd1;
            end
            if (i_in_valid && !r_busy) begin
                if (r_count == 2'd0) begin
                    r_c0    <= w_cur;
                    r_count <= 2'd1;
                end else if (r_count == 2'd1) begin
                    r_c1    <= w_cur;
                    r_count <= 2'd2;
                end else begin
                    r_count   <= 2'd0;
                    r_busy    <= 1'b1;
                    r_step    <= '0;
                    r_corners <= {r_c0, r_c1, w_cur};
                    for (int k = 0; k < 3; k++) begin
                        r_e1[k] <= fld(r_c1, k) - fld(r_c0, k);
                        r_e2[k] <= {w_p[k][CW-1], w_p[k]} - fld(r_c0, k);
                    end
                    r_d1 <= fld(r_c1, 4) - fld(r_c0, 4);
                    r_d2 <= {w_v[CW-1], w_v} - fld(r_c0, 4);
                end
            end
        end
    end

    assign o_tri_valid   = r_done;
    assign o_tri_corners = r_corners;
    assign o_tri_mag     = r_mag;
    assign o_tri_neg     = r_neg;

    // a triangle leaves only after its three terms are formed
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tri_valid |-> r_busy)
        else $error("triangle shown while idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tri_valid && !i_tri_ready) |=> o_tri_valid)
        else $error("triangle dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("corner count out of range");
endmodule

[rtl/tta_back.sv]
// back end: normalizes the tangent (sqrt and divides bit-serial) and emits the corners
module tta_back #(
    parameter int CW = 32,
    parameter int PW = 48,
    parameter int MAGW = 130
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tri_valid,
    output logic              o_tri_ready,
    input  logic [3*PW-1:0]   i_tri_corners,
    input  logic [3*MAGW-1:0] i_tri_mag,
    input  logic [2:0]        i_tri_neg,
    tta_if.source             out_ch
);
    localparam int NB   = tta_pkg::NORM_BITS;
    localparam int TF   = tta_pkg::TAN_FRAC;
    localparam int TW   = tta_pkg::TAN_W;
    localparam int LW   = $clog2(MAGW + 1);
    localparam int QW   = NB + TF + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_LEN, S_NORM, S_SQ, S_SQRT, S_DIV, S_EMIT
    } t_state;

    t_state             r_state;
    logic [3*PW-1:0]    r_corners;
    logic [MAGW-1:0]    r_mag [3];
    logic [2:0]         r_neg;
    logic [LW-1:0]      r_n;
    logic [1:0]         r_i;
    logic [NB-1:0]      r_m [3];
    logic [63:0]        r_s;
    // square root
    logic [63:0]        r_x, r_res, r_bit;
    // divider
    logic [QW-1:0]      r_num;
    logic [QW-1:0]      r_quo;
    logic [NB:0]        r_rem;
    logic [5:0]         r_cnt;
    logic [TW-1:0]      r_t [3];
    logic [1:0]         r_k;
    logic               r_out_valid;

    // bit length of the current magnitude
    logic [LW-1:0] w_bl;
    always_comb begin
        w_bl = '0;
        for (int b = 0; b < MAGW; b++) begin
            if (r_mag[r_i][b]) begin
                w_bl = LW'(b + 1);
            end
        end
    end

    logic [MAGW-1:0] w_sh;
    always_comb begin
        if (r_n > LW'(NB)) begin
            w_sh = r_mag[r_i] >> (r_n - LW'(NB));
        end else begin
            w_sh = r_mag[r_i] << (LW'(NB) - r_n);
        end
    end

    logic [63:0] w_sq;
    assign w_sq = 64'(r_m[r_i]) * 64'(r_m[r_i]);

    logic [NB+1:0] w_trial;
    assign w_trial = {r_rem, r_num[QW-1]} - {1'b0, r_res[NB:0]};

    assign o_tri_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_tri_valid) begin
                        r_corners <= i_tri_corners;
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= i_tri_mag[k*MAGW +: MAGW];
                            r_t[k]   <= '0;
                        end
                        r_neg   <= i_tri_neg;
                        r_n     <= '0;
                        r_i     <= '0;
                        r_state <= S_LEN;
                    end
                end
                // common bit length, one component a cycle
                S_LEN: begin
                    if (w_bl > r_n) begin
                        r_n <= w_bl;
                    end
                    if (r_i == 2'd2) begin
                        r_i     <= '0;
                        r_state <= (w_bl == '0 && r_n == '0) ? S_EMIT : S_NORM;
                        r_k     <= '0;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
                S_NORM: begin
                    r_m[r_i] <= w_sh[NB-1:0];
                    if (r_i == 2'd2) begin
                        r_i     <= '0;
                        r_s     <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
                S_SQ: begin
                    r_s <= r_s + w_sq;
                    r_i <= r_i + 2'd1;
                    if (r_i == 2'd2) begin
                        r_x     <= r_s + w_sq;
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                // digit-by-digit root, one bit pair a cycle
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_i     <= '0;
                        r_num   <= QW'(r_m[0]) << TF;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        if (r_x >= r_res + r_bit) begin
                            r_x   <= r_x - (r_res + r_bit);
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                // restoring divide of (m<<14 + L/2) by L, one bit a cycle
                S_DIV: begin
                    if (r_cnt == 6'd0 && r_quo == '0 && r_rem == '0) begin
                        r_num <= r_num + QW'(r_res[NB:1]);
                        r_cnt <= 6'd1;
                    end else if (r_cnt <= 6'(QW)) begin
                        if (!w_trial[NB+1]) begin
                            r_rem <= w_trial[NB:0];
                            r_quo <= {r_quo[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[NB-1:0], r_num[QW-1]};
                            r_quo <= {r_quo[QW-2:0], 1'b0};
                        end
                        r_num <= {r_num[QW-2:0], 1'b0};
                        r_cnt <= r_cnt + 6'd1;
                    end else begin
                        r_t[r_i] <= r_neg[r_i] ? -TW'(r_quo) : TW'(r_quo);
                        r_rem    <= '0;
                        r_quo    <= '0;
                        r_cnt    <= '0;
                        if (r_i == 2'd2) begin
                            r_k     <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_i   <= r_i + 2'd1;
                            r_num <= QW'(r_m[r_i + 2'd1]) << TF;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || out_ch.ready) begin
                        r_out_valid <= 1'b1;
                        out_ch.data <= {r_corners[(2-r_k)*PW +: PW],
                                        r_t[0], r_t[1], r_t[2], r_k == 2'd2};
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd2) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state != S_EMIT && r_out_valid && out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_ch.valid = r_out_valid;

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_res != '0))
        else $error("divide by zero length");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tri_valid && o_tri_ready) |=> (r_state == S_LEN))
        else $error("triangle not taken");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
endmodule

[rtl/triangle_tangent_assembler.sv]
// top level of the triangle tangent assembler
// channel  dir  handshake              payload
// in_ch    in   in_ch.valid/ready      pos x,y,z, tex u,v, has_texcoord, material
// out_ch   out  out_ch.valid/ready     vert x,y,z,u,v, material, tangent x,y,z, last
// cfg      in   i_cfg_we               index 0..2 offset x,y,z
// first two corners are taken one a cycle while idle; the third starts the tangent work
// per triangle: the front forms the three tangent terms; the back then finds the bit length,
// normalizes, squares, takes the root, runs three serial divides and emits the corners
// the front holds one finished triangle and stalls its input until the back takes it
// reset is synchronous active low and clears the corner count and all handshakes
module triangle_tangent_assembler #(
    parameter int COORD_WIDTH    = 32,
    parameter int MATERIAL_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    tta_if.sink                    in_ch,
    tta_if.source                  out_ch
);
    localparam int CW   = COORD_WIDTH;
    localparam int MW   = MATERIAL_WIDTH;
    localparam int PW   = 5 * CW + MW;
    localparam int MAGW = 2 * CW + 2;

    logic [CW-1:0] r_off_x, r_off_y, r_off_z;

    // offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tta_pkg::REG_OFFSET_X: r_off_x <= i_cfg_data;
                tta_pkg::REG_OFFSET_Y: r_off_y <= i_cfg_data;
                tta_pkg::REG_OFFSET_Z: r_off_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic              w_tri_valid, w_tri_ready;
    logic [3*PW-1:0]   w_corners;
    logic [3*MAGW-1:0] w_mag;
    logic [2:0]        w_neg;

    tta_front #(.CW(CW), .MW(MW), .PW(PW), .MAGW(MAGW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_pos_x(in_ch.data[4*CW+1+MW +: CW]),
        .i_pos_y(in_ch.data[3*CW+1+MW +: CW]),
        .i_pos_z(in_ch.data[2*CW+1+MW +: CW]),
        .i_tex_u(in_ch.data[CW+1+MW +: CW]),
        .i_tex_v(in_ch.data[1+MW +: CW]),
        .i_has_tex(in_ch.data[MW]),
        .i_material(in_ch.data[MW-1:0]),
        .i_off_x(r_off_x), .i_off_y(r_off_y), .i_off_z(r_off_z),
        .o_tri_valid(w_tri_valid), .i_tri_ready(w_tri_ready),
        .o_tri_corners(w_corners), .o_tri_mag(w_mag), .o_tri_neg(w_neg)
    );

    tta_back #(.CW(CW), .PW(PW), .MAGW(MAGW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_tri_valid(w_tri_valid), .o_tri_ready(w_tri_ready),
        .i_tri_corners(w_corners), .i_tri_mag(w_mag), .i_tri_neg(w_neg),
        .out_ch(out_ch)
    );
endmodule
